// ===== design/stream_prefetch_trainer_assert.svh =====
// Assertion macros for the stream prefetch trainer.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef STREAM_PREFETCH_TRAINER_ASSERT_SVH
`define STREAM_PREFETCH_TRAINER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SPT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("spt check failed");

// Next-cycle implication, checked outside reset
`define SPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("spt check failed");

`endif

// ===== design/spt_pkg.sv =====
// Shared types and constants for the stream prefetch trainer.
// No dependencies.
package spt_pkg;

    localparam int ADDR_BITS     = 48;
    localparam int BLOCK_BYTES   = 64;
    localparam int BLOCK_SHIFT   = $clog2(BLOCK_BYTES);
    localparam int TABLE_ENTRIES = 8;
    localparam int CONTEXTS      = 4;
    localparam int DEG_BITS      = 5;
    localparam int DIST_BITS     = 16;
    localparam int MAX_DEGREE    = 16;
    localparam int CFG_ADDR_BITS = 3;

    // Register indexes
    localparam logic REG_DEGREE   = 1'b0;
    localparam logic REG_DISTANCE = 1'b1;

    typedef logic [ADDR_BITS-1:0] addr_t;

    typedef enum logic [1:0] {
        ST_INV   = 2'd0,
        ST_TRAIN = 2'd1,
        ST_MON   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        TR_NONE = 2'd0,
        TR_ASC  = 2'd1,
        TR_DESC = 2'd2
    } trend_t;

    typedef struct packed {
        addr_t      access_address;
        logic [1:0] core_index;
        logic       has_pc;
    } in_item_t;

    typedef struct packed {
        addr_t prefetch_address;
        logic  last_of_run;
    } out_item_t;

    typedef struct packed {
        addr_t a;
        addr_t b;
        logic  sub;
    } alu_req_t;

    typedef struct packed {
        addr_t res;
        logic  gt;
        logic  lt;
        addr_t absd;
    } alu_rsp_t;

    typedef struct packed {
        addr_t origin;
        addr_t win_start;
        addr_t win_end;
    } wide_entry_t;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_READ    = 10'b00_0000_0010,
        S_CMP_LO  = 10'b00_0000_0100,
        S_CMP_HI  = 10'b00_0000_1000,
        S_PROMOTE = 10'b00_0001_0000,
        S_EMIT    = 10'b00_0010_0000,
        S_SPAN    = 10'b00_0100_0000,
        S_SHIFT   = 10'b00_1000_0000,
        S_ALLOC   = 10'b01_0000_0000,
        S_AGE     = 10'b10_0000_0000
    } state_t;

endpackage

// ===== design/spt_alu.sv =====
// Shared address add/subtract and compare unit.
// Depends on spt_pkg.
module spt_alu (
    input  spt_pkg::alu_req_t req,
    output spt_pkg::alu_rsp_t rsp
);

    // One wide add or subtract plus magnitude compare and absolute difference
    always_comb begin
        rsp.res  = req.sub ? (req.a - req.b) : (req.a + req.b);
        rsp.gt   = req.a > req.b;
        rsp.lt   = req.a < req.b;
        rsp.absd = rsp.gt ? (req.a - req.b) : (req.b - req.a);
    end

endmodule

// ===== design/spt_out.sv =====
// Output register stage for prefetch items.
// Depends on spt_pkg.
module spt_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  spt_pkg::out_item_t  load_data,
    output logic                can_load,
    output logic                m_valid,
    input  logic                m_ready,
    output spt_pkg::out_item_t  m_data
);

    logic               valid_reg;
    spt_pkg::out_item_t data_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    // Hold item until taken; reload in the same cycle it drains
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

endmodule

// ===== design/stream_prefetch_trainer.sv =====
// Stream prefetch trainer: one demand access per item, scanned against the
// requesting core's stream table one entry at a time through a single shared
// address adder/comparator. An item is accepted, then each entry scanned takes a
// memory read, then a compare (a monitored candidate whose start check passes
// adds one more compare); a trained entry may then be promoted, or on a miss one
// is allocated; prefetches are issued one per cycle while the result side does
// not stall, the window is moved (span check, then shift) and the ages are
// updated. Items with has_pc low are accepted without a scan.
// There is no clearing pass after reset; s_ready is high only when idle.
`include "stream_prefetch_trainer_assert.svh"

module stream_prefetch_trainer #(
    parameter int TABLE_ENTRIES = spt_pkg::TABLE_ENTRIES,
    parameter int CONTEXTS      = spt_pkg::CONTEXTS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  spt_pkg::in_item_t                    s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output spt_pkg::out_item_t                   m_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [spt_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    localparam int IW    = $clog2(TABLE_ENTRIES);
    localparam int SLOTS = CONTEXTS * TABLE_ENTRIES;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Configuration registers
    logic [spt_pkg::DEG_BITS-1:0]  degree_reg;
    logic [spt_pkg::DIST_BITS-1:0] dist_reg;
    logic                          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg <= spt_pkg::DEG_BITS'(1);
            dist_reg   <= spt_pkg::DIST_BITS'(1024);
        end else if (psel && penable && pwrite && pready) begin
            case (cfg_idx)
                spt_pkg::REG_DEGREE:   degree_reg <= pwdata[spt_pkg::DEG_BITS-1:0];
                spt_pkg::REG_DISTANCE: dist_reg   <= pwdata[spt_pkg::DIST_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            spt_pkg::REG_DEGREE:   prdata = {{(32-spt_pkg::DEG_BITS){1'b0}}, degree_reg};
            spt_pkg::REG_DISTANCE: prdata = {{(32-spt_pkg::DIST_BITS){1'b0}}, dist_reg};
            default:               prdata = '0;
        endcase
    end

    // Sequencer state
    spt_pkg::state_t              state_reg;
    logic [IW-1:0]                idx_reg;
    logic [IW-1:0]                hit_reg;
    logic [SW-1:0]                base_reg;
    spt_pkg::addr_t               blk_reg;
    logic [spt_pkg::DEG_BITS-1:0] deg_reg;
    spt_pkg::addr_t               step_reg;
    spt_pkg::addr_t               acc_reg;
    logic [spt_pkg::DEG_BITS-1:0] cnt_reg;
    spt_pkg::trend_t              dir_reg;
    spt_pkg::trend_t              trend_reg;
    logic                         big_reg;

    // Per-slot narrow state in flops
    spt_pkg::status_t status_reg [SLOTS];
    spt_pkg::trend_t  first_reg  [SLOTS];
    spt_pkg::trend_t  second_reg [SLOTS];
    spt_pkg::trend_t  sdir_reg   [SLOTS];
    logic [IW-1:0]    age_reg    [SLOTS];

    // Wide per-slot fields in a memory (read for every entry scanned, used only once the status makes them live)
    spt_pkg::wide_entry_t mem [SLOTS];
    spt_pkg::wide_entry_t rd_reg;
    spt_pkg::wide_entry_t wdata;
    logic                 we;
    logic [SW-1:0]        waddr;

    logic [SW-1:0]                  slot;
    spt_pkg::status_t               cur_status;
    spt_pkg::alu_req_t              alu_req;
    spt_pkg::alu_rsp_t              alu_rsp;
    spt_pkg::addr_t                 train_lim;
    spt_pkg::trend_t                obs_trend;
    logic                           last_idx;
    logic [IW-1:0]                  victim;
    logic                           out_load;
    logic                           out_can;
    spt_pkg::out_item_t             out_data;
    logic [spt_pkg::DEG_BITS-1:0]   deg_sat;
    logic                           core_ok;

    assign slot       = base_reg + SW'(idx_reg);
    assign cur_status = status_reg[slot];
    assign train_lim  = spt_pkg::addr_t'(dist_reg[spt_pkg::DIST_BITS-1:1])
                        << spt_pkg::BLOCK_SHIFT;
    assign obs_trend  = alu_rsp.gt ? spt_pkg::TR_ASC : spt_pkg::TR_DESC;
    assign last_idx   = (idx_reg == IW'(TABLE_ENTRIES - 1));
    assign deg_sat    = (degree_reg > spt_pkg::DEG_BITS'(spt_pkg::MAX_DEGREE))
                        ? spt_pkg::DEG_BITS'(spt_pkg::MAX_DEGREE) : degree_reg;
    assign core_ok    = (32'(s_data.core_index) < CONTEXTS);
    assign s_ready    = (state_reg == spt_pkg::S_IDLE);

    spt_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    spt_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (out_load),
        .load_data (out_data),
        .can_load  (out_can),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Shared unit operand select
    always_comb begin
        alu_req.a   = blk_reg;
        alu_req.b   = rd_reg.origin;
        alu_req.sub = 1'b1;
        case (state_reg)
            spt_pkg::S_CMP_LO: begin
                alu_req.b = (cur_status == spt_pkg::ST_MON) ? rd_reg.win_start : rd_reg.origin;
            end
            spt_pkg::S_CMP_HI: begin
                alu_req.b = rd_reg.win_end;
            end
            spt_pkg::S_PROMOTE: begin
                alu_req.b   = step_reg;
                alu_req.sub = (trend_reg == spt_pkg::TR_DESC);
            end
            spt_pkg::S_EMIT: begin
                alu_req.a   = acc_reg;
                alu_req.b   = spt_pkg::addr_t'(spt_pkg::BLOCK_BYTES);
                alu_req.sub = (dir_reg == spt_pkg::TR_DESC);
            end
            spt_pkg::S_SPAN: begin
                alu_req.a = (dir_reg == spt_pkg::TR_ASC) ? acc_reg : rd_reg.win_start;
                alu_req.b = (dir_reg == spt_pkg::TR_ASC) ? rd_reg.win_start : acc_reg;
            end
            spt_pkg::S_SHIFT: begin
                alu_req.a   = rd_reg.win_start;
                alu_req.b   = step_reg;
                alu_req.sub = (dir_reg == spt_pkg::TR_DESC);
            end
            default: ;
        endcase
    end

    // Victim: lowest invalid entry, else the oldest
    always_comb begin
        logic found;
        found  = 1'b0;
        victim = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!found && status_reg[base_reg + SW'(i)] == spt_pkg::ST_INV) begin
                victim = IW'(i);
                found  = 1'b1;
            end
        end
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!found && age_reg[base_reg + SW'(i)] == IW'(TABLE_ENTRIES - 1)) begin
                victim = IW'(i);
                found  = 1'b1;
            end
        end
    end

    // Memory write select
    always_comb begin
        we    = 1'b0;
        waddr = slot;
        wdata = rd_reg;
        case (state_reg)
            spt_pkg::S_PROMOTE: begin
                we              = 1'b1;
                wdata.win_start = rd_reg.origin;
                wdata.win_end   = alu_rsp.res;
            end
            spt_pkg::S_SHIFT: begin
                we              = 1'b1;
                wdata.win_start = big_reg ? alu_rsp.res : rd_reg.win_start;
                wdata.win_end   = acc_reg;
            end
            spt_pkg::S_ALLOC: begin
                we    = 1'b1;
                waddr = base_reg + SW'(victim);
                wdata = '{origin: blk_reg, win_start: '0, win_end: '0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (state_reg == spt_pkg::S_READ) begin
            rd_reg <= mem[slot];
        end
    end

    // Prefetch item generation
    assign out_load = (state_reg == spt_pkg::S_EMIT) && out_can;
    assign out_data = '{prefetch_address: alu_rsp.res,
                        last_of_run: (cnt_reg == deg_reg - spt_pkg::DEG_BITS'(1))};

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spt_pkg::S_IDLE;
            idx_reg   <= '0;
            hit_reg   <= '0;
            for (int c = 0; c < CONTEXTS; c++) begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    status_reg[c*TABLE_ENTRIES+i] <= spt_pkg::ST_INV;
                    first_reg[c*TABLE_ENTRIES+i]  <= spt_pkg::TR_NONE;
                    second_reg[c*TABLE_ENTRIES+i] <= spt_pkg::TR_NONE;
                    sdir_reg[c*TABLE_ENTRIES+i]   <= spt_pkg::TR_NONE;
                    age_reg[c*TABLE_ENTRIES+i]    <= IW'(i);
                end
            end
        end else begin
            case (state_reg)
                spt_pkg::S_IDLE: begin
                    if (s_valid && s_data.has_pc && core_ok) begin
                        blk_reg   <= s_data.access_address
                                     & ~spt_pkg::addr_t'(spt_pkg::BLOCK_BYTES - 1);
                        base_reg  <= SW'(32'(s_data.core_index) * TABLE_ENTRIES);
                        deg_reg   <= deg_sat;
                        step_reg  <= spt_pkg::addr_t'(deg_sat) << spt_pkg::BLOCK_SHIFT;
                        idx_reg   <= '0;
                        state_reg <= spt_pkg::S_READ;
                    end
                end
                spt_pkg::S_READ: begin
                    state_reg <= spt_pkg::S_CMP_LO;
                end
                spt_pkg::S_CMP_LO: begin
                    dir_reg <= sdir_reg[slot];
                    if (cur_status == spt_pkg::ST_MON &&
                        ((sdir_reg[slot] == spt_pkg::TR_ASC && alu_rsp.gt) ||
                         (sdir_reg[slot] == spt_pkg::TR_DESC && alu_rsp.lt))) begin
                        state_reg <= spt_pkg::S_CMP_HI;
                    end else if (cur_status == spt_pkg::ST_TRAIN &&
                                 alu_rsp.absd <= train_lim) begin
                        hit_reg   <= idx_reg;
                        trend_reg <= obs_trend;
                        if (first_reg[slot] == spt_pkg::TR_NONE) begin
                            first_reg[slot] <= obs_trend;
                            state_reg       <= spt_pkg::S_AGE;
                        end else if (first_reg[slot] == obs_trend) begin
                            second_reg[slot] <= obs_trend;
                            state_reg        <= spt_pkg::S_PROMOTE;
                        end else begin
                            // Trends disagree: entry dropped, still a hit
                            status_reg[slot] <= spt_pkg::ST_INV;
                            first_reg[slot]  <= spt_pkg::TR_NONE;
                            second_reg[slot] <= spt_pkg::TR_NONE;
                            sdir_reg[slot]   <= spt_pkg::TR_NONE;
                            state_reg        <= spt_pkg::S_AGE;
                        end
                    end else if (last_idx) begin
                        state_reg <= spt_pkg::S_ALLOC;
                    end else begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= spt_pkg::S_READ;
                    end
                end
                spt_pkg::S_CMP_HI: begin
                    if ((dir_reg == spt_pkg::TR_ASC && alu_rsp.lt) ||
                        (dir_reg == spt_pkg::TR_DESC && alu_rsp.gt)) begin
                        hit_reg   <= idx_reg;
                        acc_reg   <= rd_reg.win_end;
                        cnt_reg   <= '0;
                        state_reg <= (deg_reg == '0) ? spt_pkg::S_SPAN : spt_pkg::S_EMIT;
                    end else if (last_idx) begin
                        state_reg <= spt_pkg::S_ALLOC;
                    end else begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= spt_pkg::S_READ;
                    end
                end
                spt_pkg::S_PROMOTE: begin
                    status_reg[slot] <= spt_pkg::ST_MON;
                    sdir_reg[slot]   <= trend_reg;
                    state_reg        <= spt_pkg::S_AGE;
                end
                spt_pkg::S_EMIT: begin
                    if (out_can) begin
                        acc_reg <= alu_rsp.res;
                        cnt_reg <= cnt_reg + spt_pkg::DEG_BITS'(1);
                        if (out_data.last_of_run) begin
                            state_reg <= spt_pkg::S_SPAN;
                        end
                    end
                end
                spt_pkg::S_SPAN: begin
                    big_reg   <= alu_rsp.res > spt_pkg::addr_t'(dist_reg);
                    state_reg <= spt_pkg::S_SHIFT;
                end
                spt_pkg::S_SHIFT: begin
                    state_reg <= spt_pkg::S_AGE;
                end
                spt_pkg::S_ALLOC: begin
                    status_reg[base_reg + SW'(victim)] <= spt_pkg::ST_TRAIN;
                    first_reg[base_reg + SW'(victim)]  <= spt_pkg::TR_NONE;
                    second_reg[base_reg + SW'(victim)] <= spt_pkg::TR_NONE;
                    sdir_reg[base_reg + SW'(victim)]   <= spt_pkg::TR_NONE;
                    hit_reg   <= victim;
                    state_reg <= spt_pkg::S_AGE;
                end
                spt_pkg::S_AGE: begin
                    // Entries younger than the hit age by one; hit becomes newest
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (IW'(i) == hit_reg) begin
                            age_reg[base_reg + SW'(i)] <= '0;
                        end else if (age_reg[base_reg + SW'(i)] <
                                     age_reg[base_reg + SW'(hit_reg)]) begin
                            age_reg[base_reg + SW'(i)] <= age_reg[base_reg + SW'(i)] + IW'(1);
                        end
                    end
                    state_reg <= spt_pkg::S_IDLE;
                end
                default: begin
                    state_reg <= spt_pkg::S_IDLE;
                end
            endcase
        end
    end

    // Checks
    `SPT_ASSERT_NOW(a_emit_count, state_reg == spt_pkg::S_EMIT, cnt_reg < deg_reg)
    `SPT_ASSERT_NOW(a_alloc_after_scan, state_reg == spt_pkg::S_ALLOC, last_idx)
    `SPT_ASSERT_NEXT(a_age_done, state_reg == spt_pkg::S_AGE, state_reg == spt_pkg::S_IDLE)

endmodule

// ===== bench/spt_checker.sv =====
// Checker for the stream prefetch trainer: watches the access, prefetch and
// register channels, predicts the prefetch items and compares them in order.
// Depends on spt_pkg for the item types, states and trends.
`timescale 1ns / 100ps

module spt_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  spt_pkg::in_item_t                 s_data,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  spt_pkg::out_item_t                m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [spt_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                       pwdata,
    input  logic                              pready,
    output int                                fail_count,
    output int                                pending,
    output int                                accesses_seen,
    output int                                prefetches_seen
);

    localparam int SLOTS = spt_pkg::CONTEXTS * spt_pkg::TABLE_ENTRIES;

    // Shadow copy of the stream tables and registers
    spt_pkg::status_t  ent_stat [SLOTS];
    spt_pkg::trend_t   trend_a  [SLOTS];
    spt_pkg::trend_t   trend_b  [SLOTS];
    spt_pkg::trend_t   dirn     [SLOTS];
    spt_pkg::addr_t    org      [SLOTS];
    spt_pkg::addr_t    wst      [SLOTS];
    spt_pkg::addr_t    wend     [SLOTS];
    int                age      [SLOTS];
    logic [spt_pkg::DEG_BITS-1:0]  degree_r;
    logic [spt_pkg::DIST_BITS-1:0] distance_r;

    spt_pkg::out_item_t expected_prefetches[$];

    initial begin
        fail_count      = 0;
        pending         = 0;
        accesses_seen   = 0;
        prefetches_seen = 0;
    end

    function automatic void clear_stream(int e);
        ent_stat[e] = spt_pkg::ST_INV;
        trend_a[e]  = spt_pkg::TR_NONE;
        trend_b[e]  = spt_pkg::TR_NONE;
        dirn[e]     = spt_pkg::TR_NONE;
        org[e]      = '0;
        wst[e]      = '0;
        wend[e]     = '0;
    endfunction

    // Append one predicted prefetch item
    function automatic void queue_prefetch(spt_pkg::addr_t a, logic last);
        spt_pkg::out_item_t it;
        it.prefetch_address = a;
        it.last_of_run      = last;
        expected_prefetches.insert(expected_prefetches.size(), it);
    endfunction

    // Scan the core's table, queue the prefetches and update the shadow state
    function automatic void predict_prefetches(spt_pkg::in_item_t it);
        spt_pkg::addr_t blk, stp, lim, ne, span, dif;
        int base, hit, e, k, dg, inv, best;
        spt_pkg::trend_t tr;
        logic asc, dsc;
        if (!it.has_pc) return;
        blk  = {it.access_address[spt_pkg::ADDR_BITS-1:spt_pkg::BLOCK_SHIFT],
                {spt_pkg::BLOCK_SHIFT{1'b0}}};
        dg   = (degree_r > spt_pkg::MAX_DEGREE) ? spt_pkg::MAX_DEGREE : int'(degree_r);
        stp  = spt_pkg::addr_t'(dg * spt_pkg::BLOCK_BYTES);
        lim  = spt_pkg::addr_t'((distance_r >> 1) * spt_pkg::BLOCK_BYTES);
        base = int'(it.core_index) * spt_pkg::TABLE_ENTRIES;
        hit  = -1;
        for (k = 0; k < spt_pkg::TABLE_ENTRIES; k++) begin
            e = base + k;
            if (ent_stat[e] == spt_pkg::ST_MON) begin
                asc = (dirn[e] == spt_pkg::TR_ASC);
                dsc = (dirn[e] == spt_pkg::TR_DESC);
                if (asc && wst[e] < blk && wend[e] > blk) begin
                    for (int d = 1; d <= dg; d++)
                        queue_prefetch(wend[e] + spt_pkg::addr_t'(spt_pkg::BLOCK_BYTES * d),
                                       d == dg);
                    ne   = wend[e] + stp;
                    span = ne - wst[e];
                end else if (dsc && wst[e] > blk && wend[e] < blk) begin
                    for (int d = 1; d <= dg; d++)
                        queue_prefetch(wend[e] - spt_pkg::addr_t'(spt_pkg::BLOCK_BYTES * d),
                                       d == dg);
                    ne   = wend[e] - stp;
                    span = wst[e] - ne;
                end else begin
                    continue;
                end
                // window too long: drag the start along
                if (span > spt_pkg::addr_t'(distance_r))
                    wst[e] = asc ? wst[e] + stp : wst[e] - stp;
                wend[e] = ne;
                hit = k;
                break;
            end else if (ent_stat[e] == spt_pkg::ST_TRAIN) begin
                dif = (blk > org[e]) ? blk - org[e] : org[e] - blk;
                if (dif > lim) continue;
                tr = (blk > org[e]) ? spt_pkg::TR_ASC : spt_pkg::TR_DESC;
                if (trend_a[e] == spt_pkg::TR_NONE) begin
                    trend_a[e] = tr;
                end else begin
                    trend_b[e] = tr;
                    if (trend_a[e] == tr) begin
                        dirn[e]     = tr;
                        wst[e]      = org[e];
                        wend[e]     = (tr == spt_pkg::TR_ASC) ? blk + stp : blk - stp;
                        ent_stat[e] = spt_pkg::ST_MON;
                    end else begin
                        clear_stream(e);
                    end
                end
                hit = k;
                break;
            end
        end
        // miss: lowest invalid entry, else oldest
        if (hit < 0) begin
            inv = -1;
            for (k = 0; k < spt_pkg::TABLE_ENTRIES; k++)
                if (inv < 0 && ent_stat[base + k] == spt_pkg::ST_INV) inv = k;
            if (inv < 0) begin
                inv  = 0;
                best = age[base];
                for (k = 1; k < spt_pkg::TABLE_ENTRIES; k++)
                    if (age[base + k] > best) begin
                        best = age[base + k];
                        inv  = k;
                    end
            end
            e = base + inv;
            clear_stream(e);
            ent_stat[e] = spt_pkg::ST_TRAIN;
            org[e]      = blk;
            hit         = inv;
        end
        e = base + hit;
        for (k = 0; k < spt_pkg::TABLE_ENTRIES; k++)
            if (age[base + k] < age[e]) age[base + k]++;
        age[e] = 0;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            degree_r   = 5'd1;
            distance_r = 16'd1024;
            for (int e = 0; e < SLOTS; e++) begin
                clear_stream(e);
                age[e] = e % spt_pkg::TABLE_ENTRIES;
            end
            expected_prefetches.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == spt_pkg::REG_DEGREE)
                    degree_r = pwdata[spt_pkg::DEG_BITS-1:0];
                else if (paddr[2] == spt_pkg::REG_DISTANCE)
                    distance_r = pwdata[spt_pkg::DIST_BITS-1:0];
            end
            if (s_valid && s_ready) begin
                accesses_seen++;
                predict_prefetches(s_data);
            end
            // compare each prefetch item with the oldest prediction
            if (m_valid && m_ready) begin
                prefetches_seen++;
                if (expected_prefetches.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected prefetch item: addr %h last %b",
                                 m_data.prefetch_address, m_data.last_of_run);
                end else begin
                    spt_pkg::out_item_t exp_it;
                    exp_it = expected_prefetches.pop_front();
                    if (exp_it.prefetch_address !== m_data.prefetch_address ||
                        exp_it.last_of_run !== m_data.last_of_run) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("prefetch mismatch: expected %h/%b got %h/%b",
                                     exp_it.prefetch_address, exp_it.last_of_run,
                                     m_data.prefetch_address, m_data.last_of_run);
                    end
                end
            end
        end
        pending = expected_prefetches.size();
    end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the stream prefetch trainer: clock, reset, access and
// register stimulus, result-side flow control and the verdict.
// Depends on spt_pkg, stream_prefetch_trainer and spt_checker.
`timescale 1ns / 100ps

module tb;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    spt_pkg::in_item_t                 s_data = '0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    spt_pkg::out_item_t                m_data;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [spt_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
    logic [31:0]                       pwdata = '0;
    logic [31:0]                       prdata;
    logic                              pready;

    int fail_count, pending, accesses_seen, prefetches_seen;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    stream_prefetch_trainer u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    spt_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending(pending),
        .accesses_seen(accesses_seen), .prefetches_seen(prefetches_seen)
    );

    // Result side: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one access item; returns right after the edge that accepts it
    task automatic send_access(spt_pkg::addr_t a, logic [1:0] core, logic pc);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{access_address: a, core_index: core, has_pc: pc};
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
    endtask

    // Wait for the block to go quiet before touching registers or ending
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (60) @(posedge aclk);
    endtask

    task automatic reg_write(logic idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // A trained stream followed by accesses that mostly land in its window
    task automatic run_stream(int len);
        spt_pkg::addr_t base, a;
        logic [1:0] core;
        logic up;
        int reach;
        base  = spt_pkg::addr_t'({$urandom, $urandom});
        core  = 2'($urandom_range(3));
        up    = 1'($urandom_range(1));
        reach = 2;
        for (int i = 0; i < len; i++) begin
            if (i < 3) a = up ? base + spt_pkg::addr_t'(i * 64) : base - spt_pkg::addr_t'(i * 64);
            else begin
                a = spt_pkg::addr_t'($urandom_range(1, reach) * 64);
                a = up ? base + a : base - a;
                reach++;
            end
            send_access(a | spt_pkg::addr_t'($urandom_range(63)), core,
                        $urandom_range(19) != 0);
        end
    endtask

    task automatic random_phase(int n);
        int sent;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(99) < 80) begin
                run_stream(8);
                sent += 8;
            end else begin
                send_access(spt_pkg::addr_t'({$urandom, $urandom}), 2'($urandom_range(3)),
                            1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset registers, light idling on the access side, heavy on the result side
        tx_idle_pct = 26;
        rx_idle_pct = 73;
        send_access({spt_pkg::ADDR_BITS{1'b1}}, 2'd3, 1'b0);
        send_access({spt_pkg::ADDR_BITS{1'b1}}, 2'd0, 1'b1);
        // ascending stream trains, then a monitored hit
        send_access(48'h1000, 2'd0, 1'b1);
        send_access(48'h1040, 2'd0, 1'b1);
        send_access(48'h1080, 2'd0, 1'b1);
        send_access(48'h1090, 2'd0, 1'b1);
        // equal block trains descending, window wraps below zero
        send_access(48'h40, 2'd1, 1'b1);
        send_access(48'h0, 2'd1, 1'b1);
        send_access(48'h0, 2'd1, 1'b1);
        // disagreeing trends clear the entry
        send_access(48'h8000, 2'd2, 1'b1);
        send_access(48'h8040, 2'd2, 1'b1);
        send_access(48'h7fc0, 2'd2, 1'b1);
        // fill a table and force replacement of the oldest entry
        for (int i = 0; i < 9; i++)
            send_access(spt_pkg::addr_t'(i) * 48'h100000 + 48'hfff, 2'd3, 1'b1);
        random_phase(60);
        drain();

        reg_write(spt_pkg::REG_DEGREE, 32'hffff_ffe0 | 32'd16);
        reg_write(spt_pkg::REG_DISTANCE, 32'hffff_ffff);
        random_phase(70);
        drain();

        tx_idle_pct = 73;
        rx_idle_pct = 26;
        reg_write(spt_pkg::REG_DEGREE, 32'd31);
        reg_write(spt_pkg::REG_DISTANCE, 32'd512);
        hold_req <= 1'b1;
        random_phase(70);
        drain();

        reg_write(spt_pkg::REG_DEGREE, 32'd0);
        reg_write(spt_pkg::REG_DISTANCE, 32'd0);
        random_phase(50);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        reg_write(spt_pkg::REG_DEGREE, 32'd4);
        reg_write(spt_pkg::REG_DISTANCE, 32'd2048);
        random_phase(80);
        drain();

        $display("covered %0d access items and %0d prefetch items over five settings",
                 accesses_seen, prefetches_seen);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
